// File: hw/rtl/spa_pkg.sv
// Shared types, codes and defaults for the segment pool allocator.
package spa_pkg;

  localparam int unsigned NumSegmentsDef  = 64;
  localparam int unsigned SegmentBytesDef = 256;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_HEAD = 2'd1,
    MARK_CONT = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    RS_DONE      = 2'd0,
    RS_BAD_ARG   = 2'd1,
    RS_NO_RUN    = 2'd2,
    RS_NOT_FOUND = 2'd3
  } rsp_status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_A1,
    S_SCAN_A2,
    S_MARK,
    S_SCAN_F,
    S_FREE_CLR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] byte_count;
    logic [31:0] region_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] start_address;
    logic [6:0]  used_segments;
    logic [6:0]  peak_segments;
    logic [6:0]  total_segments;
  } out_item_t;

  typedef struct packed {
    logic        clr_step;
    logic        load;
    logic        scan_init;
    logic        scan_from_zero;
    logic        scan_step;
    logic        mark_step;
    logic        alloc_commit;
    logic        free_head;
    logic        free_step;
    logic        res_load;
    rsp_status_e res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_zero;
    logic is_free;
    logic alloc_hit;
    logic free_hit;
    logic cont;
    logic pass_end;
    logic mark_last;
    logic res_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/spa_ctrl.sv
// Controller state machine of the segment pool allocator.
module spa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spa_pkg::dp_stat_t    stat_i,
  output spa_pkg::ctrl_cmd_t   cmd_o
);

  spa_pkg::state_e      state_q, state_d;
  spa_pkg::rsp_status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spa_pkg::S_CLEAR;
      code_q  <= spa_pkg::RS_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    code_d           = code_q;
    cmd_o            = '0;
    cmd_o.res_status = code_q;
    in_stall_o       = (state_q != spa_pkg::S_IDLE);
    case (state_q)
      spa_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = spa_pkg::S_IDLE;
      end
      spa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = spa_pkg::S_CHECK;
        end
      end
      spa_pkg::S_CHECK: begin
        if (stat_i.req_zero) begin
          code_d  = spa_pkg::RS_BAD_ARG;
          state_d = spa_pkg::S_RESP;
        end else begin
          cmd_o.scan_init      = 1'b1;
          cmd_o.scan_from_zero = stat_i.is_free;
          state_d = stat_i.is_free ? spa_pkg::S_SCAN_F : spa_pkg::S_SCAN_A1;
        end
      end
      spa_pkg::S_SCAN_A1: begin
        if (stat_i.alloc_hit) begin
          cmd_o.scan_step = 1'b1;
          state_d         = spa_pkg::S_MARK;
        end else if (stat_i.pass_end) begin
          // restart the search from segment zero
          cmd_o.scan_init      = 1'b1;
          cmd_o.scan_from_zero = 1'b1;
          state_d              = spa_pkg::S_SCAN_A2;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      spa_pkg::S_SCAN_A2: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.alloc_hit) begin
          state_d = spa_pkg::S_MARK;
        end else if (stat_i.pass_end) begin
          code_d  = spa_pkg::RS_NO_RUN;
          state_d = spa_pkg::S_RESP;
        end
      end
      spa_pkg::S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (stat_i.mark_last) begin
          cmd_o.alloc_commit = 1'b1;
          code_d             = spa_pkg::RS_DONE;
          state_d            = spa_pkg::S_RESP;
        end
      end
      spa_pkg::S_SCAN_F: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.free_hit) begin
          cmd_o.free_head = 1'b1;
          state_d         = spa_pkg::S_FREE_CLR;
        end else if (stat_i.pass_end) begin
          code_d  = spa_pkg::RS_NOT_FOUND;
          state_d = spa_pkg::S_RESP;
        end
      end
      spa_pkg::S_FREE_CLR: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.cont) begin
          cmd_o.free_step = 1'b1;
        end else begin
          code_d  = spa_pkg::RS_DONE;
          state_d = spa_pkg::S_RESP;
        end
      end
      spa_pkg::S_RESP: begin
        if (stat_i.res_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = spa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/spa_datapath.sv
// Datapath of the segment pool allocator: mark memory, scan pipeline, counters, result.
module spa_datapath #(
  parameter int unsigned NUM_SEGMENTS  = spa_pkg::NumSegmentsDef,
  parameter int unsigned SEGMENT_BYTES = spa_pkg::SegmentBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  spa_pkg::in_item_t   in_data_i,
  input  logic                out_stall_i,
  input  spa_pkg::ctrl_cmd_t  cmd_i,
  output spa_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  output spa_pkg::out_item_t  out_data_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(NUM_SEGMENTS + 1);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(NUM_SEGMENTS - 1);
  localparam logic [CNT_W-1:0] NumSeg   = CNT_W'(NUM_SEGMENTS);
  localparam logic [CNT_W-1:0] CntOne   = CNT_W'(1);
  localparam logic [31:0]      SegBytes = 32'(SEGMENT_BYTES);

  spa_pkg::mark_e    marks_q [NUM_SEGMENTS];
  spa_pkg::mark_e    rd_mark_q;
  spa_pkg::mark_e    mem_wdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;

  logic [31:0]       pool_base_q;
  spa_pkg::in_item_t req_q;
  logic [IDX_W-1:0]  clr_idx_q;
  logic [IDX_W-1:0]  cursor_q;
  logic              issue_q;
  logic [31:0]       addr_iss_q;
  logic              ev_vld_q;
  logic [IDX_W-1:0]  ev_idx_q;
  logic [31:0]       ev_addr_q;
  logic [CNT_W-1:0]  run_cnt_q, run_cnt_d;
  logic [31:0]       run_bytes_q, run_bytes_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  len_q;
  logic [IDX_W-1:0]  mk_idx_q;
  logic [CNT_W-1:0]  mk_left_q;
  logic [IDX_W-1:0]  ss_q;
  logic [CNT_W-1:0]  used_q, peak_q;
  logic [31:0]       start_q;
  spa_pkg::out_item_t res_q;
  logic              res_vld_q;

  logic              seg_free;
  logic [CNT_W-1:0]  head_sum;
  logic [CNT_W-1:0]  head_inc;
  logic [CNT_W-1:0]  used_add;

  always_comb begin
    seg_free    = ev_vld_q && (rd_mark_q == spa_pkg::MARK_FREE);
    run_cnt_d   = seg_free ? run_cnt_q + CntOne : '0;
    run_bytes_d = seg_free ? run_bytes_q + SegBytes : '0;
    head_sum    = CNT_W'(ev_idx_q) + CntOne - run_cnt_d;
    head_d      = head_sum[IDX_W-1:0];
    head_inc    = CNT_W'(head_q) + CntOne;
    used_add    = used_q + len_q;

    stat_o.clr_last  = (clr_idx_q == LastIdx);
    stat_o.is_free   = (req_q.kind == spa_pkg::KIND_FREE);
    stat_o.req_zero  = stat_o.is_free ? (req_q.region_address == 32'd0)
                                      : (req_q.byte_count == 32'd0);
    stat_o.alloc_hit = seg_free && (run_bytes_d >= req_q.byte_count);
    stat_o.free_hit  = ev_vld_q && (rd_mark_q == spa_pkg::MARK_HEAD) &&
                       (ev_addr_q == req_q.region_address);
    stat_o.cont      = ev_vld_q && (rd_mark_q == spa_pkg::MARK_CONT);
    stat_o.pass_end  = ev_vld_q && (ev_idx_q == LastIdx);
    stat_o.mark_last = (mk_left_q == CntOne);
    stat_o.res_free  = !res_vld_q || !out_stall_i;
  end

  // single write port shared by clearing, marking and releasing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_q;
    mem_wdata = spa_pkg::MARK_FREE;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.mark_step) begin
      mem_we    = 1'b1;
      mem_waddr = mk_idx_q;
      mem_wdata = (mk_idx_q == head_q) ? spa_pkg::MARK_HEAD : spa_pkg::MARK_CONT;
    end else if (cmd_i.free_head || cmd_i.free_step) begin
      mem_we    = 1'b1;
      mem_waddr = ev_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) marks_q[mem_waddr] <= mem_wdata;
    rd_mark_q <= marks_q[cursor_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      clr_idx_q   <= '0;
      issue_q     <= 1'b0;
      ev_vld_q    <= 1'b0;
      ss_q        <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) pool_base_q <= cfg_wdata_i;
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + IDX_W'(1);

      if (cmd_i.scan_init) begin
        issue_q  <= 1'b1;
        ev_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        ev_vld_q <= issue_q;
        if (issue_q && (cursor_q == LastIdx)) issue_q <= 1'b0;
      end

      if (cmd_i.alloc_commit) begin
        used_q <= used_add;
        if (peak_q < used_add) peak_q <= used_add;
        ss_q <= (head_inc == NumSeg) ? '0 : head_inc[IDX_W-1:0];
      end else if (cmd_i.free_head || cmd_i.free_step) begin
        used_q <= used_q - CntOne;
      end

      if (cmd_i.res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_vld_q && !out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;

    if (cmd_i.scan_init) begin
      cursor_q    <= cmd_i.scan_from_zero ? '0 : ss_q;
      addr_iss_q  <= pool_base_q;
      run_cnt_q   <= '0;
      run_bytes_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (issue_q) begin
        ev_idx_q   <= cursor_q;
        ev_addr_q  <= addr_iss_q;
        addr_iss_q <= addr_iss_q + SegBytes;
        if (cursor_q != LastIdx) cursor_q <= cursor_q + IDX_W'(1);
      end
      run_cnt_q   <= run_cnt_d;
      run_bytes_q <= run_bytes_d;
      if (stat_o.alloc_hit) begin
        head_q    <= head_d;
        len_q     <= run_cnt_d;
        mk_idx_q  <= head_d;
        mk_left_q <= run_cnt_d;
      end
    end

    if (cmd_i.mark_step) begin
      mk_idx_q  <= mk_idx_q + IDX_W'(1);
      mk_left_q <= mk_left_q - CntOne;
    end

    if (cmd_i.alloc_commit) start_q <= pool_base_q + 32'(head_q) * SegBytes;

    if (cmd_i.res_load) begin
      res_q.status         <= cmd_i.res_status;
      res_q.start_address  <= ((cmd_i.res_status == spa_pkg::RS_DONE) &&
                               (req_q.kind == spa_pkg::KIND_ALLOC)) ? start_q : 32'd0;
      res_q.used_segments  <= 7'(used_q);
      res_q.peak_segments  <= 7'(peak_q);
      res_q.total_segments <= 7'(NUM_SEGMENTS);
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_peak_covers_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= used_q) else $error("peak count below used count");

  a_used_in_pool : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NumSeg) else $error("used count exceeds pool size");

  a_mark_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> (mk_left_q != '0)) else $error("marking past region end");

  a_commit_adds_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |=> (used_q == $past(used_q) + $past(len_q)))
    else $error("allocation did not add region length");

endmodule

// File: hw/rtl/segment_pool_allocator.sv
// Top level of the segment pool allocator: controller plus datapath.
//
// Usage: send allocate or free requests on the in channel (in_valid_i,
// in_stall_o, in_data_i); each request yields exactly one result transfer on
// the out channel (out_valid_o, out_stall_i, out_data_o). A transfer happens
// on a clock edge with valid high and stall low. pool_base is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while the block is idle,
// as the block itself does not enforce it. One request is in work at a time.
// An allocate scans segments (one pass from the look-ahead index to the pool
// end and, on a miss, a second pass from zero) and then marks the segments of
// the run; a free scans from zero for the region's head and then releases its
// segments. The scan goes through the mark memory's one read port, one segment
// per cycle. A rejected request goes from its check straight to the result.
// After reset the block sweeps the mark memory to free, one segment per cycle,
// and holds in_stall_o high meanwhile. A finished result waits in the output
// register while the receiver stalls; the next request is accepted meanwhile
// and holds in its last step until the output register frees up.
module segment_pool_allocator #(
  parameter int unsigned NUM_SEGMENTS  = spa_pkg::NumSegmentsDef,
  parameter int unsigned SEGMENT_BYTES = spa_pkg::SegmentBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spa_pkg::out_item_t out_data_o
);

  // command and status between controller and datapath
  spa_pkg::ctrl_cmd_t cmd;
  spa_pkg::dp_stat_t  stat;

  // sequence the clearing sweep, scans, marking and result hand-off
  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hold the marks, run the scan pipeline, keep counts and the output register
  spa_datapath #(
    .NUM_SEGMENTS  (NUM_SEGMENTS),
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
